[src/cbc_pkg.sv]
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and codes for the cartridge bank controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_MAPPER_MODE    = 2'd0;
  localparam logic [1:0] CFG_ROM_BANK_COUNT = 2'd1;
  localparam logic [1:0] CFG_RAM_BYTES      = 2'd2;

  localparam int unsigned CfgW       = 18;
  localparam int unsigned BankCountW = 10;
  localparam int unsigned RamBytesW  = 18;

  // mapper modes
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_MBC1  = 2'd1;
  localparam logic [1:0] MODE_MBC3  = 2'd2;

  // bus commands
  localparam logic [1:0] CMD_ROM_READ  = 2'd0;
  localparam logic [1:0] CMD_CTL_WRITE = 2'd1;
  localparam logic [1:0] CMD_RAM_READ  = 2'd2;
  localparam logic [1:0] CMD_RAM_WRITE = 2'd3;

  // result targets
  localparam logic [2:0] TGT_OPEN_BUS  = 3'd0;
  localparam logic [2:0] TGT_ROM_READ  = 3'd1;
  localparam logic [2:0] TGT_RAM_READ  = 3'd2;
  localparam logic [2:0] TGT_RAM_WRITE = 3'd3;
  localparam logic [2:0] TGT_CTL_ACK   = 3'd4;

  localparam int unsigned MemAddrW = 23;
  localparam int unsigned RomBankW = 7;   // widest bank number before wrap
  localparam int unsigned RomOffW  = 14;  // 16 KiB ROM bank
  localparam int unsigned RamOffW  = 13;  // 8 KiB RAM bank

  localparam logic [7:0] RAM_EN_KEY = 8'h0A;

  typedef struct packed {
    logic       ram_enable;
    logic [4:0] low_rom_bank;
    logic [1:0] upper_bank_bits;
    logic       bank_mode;
    logic [6:0] mbc3_rom_select;
    logic [1:0] mbc3_ram_select;
    logic       clock_reg_selected;
  } bank_state_t;

endpackage

[src/cbc_rem_unit.sv]
// ----------------------------------------------------------------------------
// cbc_rem_unit
// Restoring remainder unit: bank number modulo ROM bank count, one bit a cycle.
// ----------------------------------------------------------------------------
module cbc_rem_unit import cbc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [RomBankW-1:0]   dividend_i,
  input  logic [BankCountW-1:0] divisor_i,
  output logic                  done_o,
  output logic [RomBankW-1:0]   rem_o
);

  localparam int unsigned CntW = $clog2(RomBankW + 1);

  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [RomBankW-1:0]   dvd_q, dvd_d;
  logic [RomBankW-1:0]   rem_q, rem_d;
  logic [BankCountW-1:0] dvs_q, dvs_d;
  logic [RomBankW:0]     shifted;

  always_comb begin
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    shifted = {rem_q, dvd_q[RomBankW-1]};
    if (start_i) begin
      cnt_d = CntW'(RomBankW);
      dvd_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      dvd_d = {dvd_q[RomBankW-2:0], 1'b0};
      // partial remainder never exceeds the dividend, so it stays RomBankW wide
      if (BankCountW'(shifted) >= dvs_q) begin
        rem_d = RomBankW'(BankCountW'(shifted) - dvs_q);
      end else begin
        rem_d = shifted[RomBankW-1:0];
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[src/cbc_bank_regs.sv]
// ----------------------------------------------------------------------------
// cbc_bank_regs
// MBC1 / MBC3 bank registers and control write decode.
// ----------------------------------------------------------------------------
module cbc_bank_regs import cbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  mapper_mode_i,
  input  logic        we_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  data_i,
  output logic        ctl_ok_o,
  output bank_state_t state_o
);

  bank_state_t st_q, st_d;
  logic        mbc1, mbc3;
  logic        ok;

  assign mbc1 = (mapper_mode_i == MODE_MBC1);
  assign mbc3 = (mapper_mode_i == MODE_MBC3);

  always_comb begin
    st_d = st_q;
    ok   = 1'b0;
    if ((mbc1 || mbc3) && !addr_i[15]) begin
      case (addr_i[14:13])
        2'b00: begin
          ok = 1'b1;
          st_d.ram_enable = (data_i[3:0] == RAM_EN_KEY[3:0]);
        end
        2'b01: begin
          ok = 1'b1;
          if (mbc1) begin
            st_d.low_rom_bank = (data_i[4:0] == '0) ? 5'd1 : data_i[4:0];
          end else begin
            st_d.mbc3_rom_select = (data_i[6:0] == '0) ? 7'd1 : data_i[6:0];
          end
        end
        2'b10: begin
          if (mbc1) begin
            ok = 1'b1;
            st_d.upper_bank_bits = data_i[1:0];
          end else if (data_i inside {[8'h00:8'h03]}) begin
            ok = 1'b1;
            st_d.mbc3_ram_select    = data_i[1:0];
            st_d.clock_reg_selected = 1'b0;
          end else if (data_i inside {[8'h08:8'h0C]}) begin
            ok = 1'b1;
            st_d.clock_reg_selected = 1'b1;
          end
        end
        default: begin
          // mode select on MBC1, clock latch on MBC3 (not modeled)
          ok = 1'b1;
          if (mbc1) begin
            st_d.bank_mode = data_i[0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.ram_enable         <= 1'b0;
      st_q.low_rom_bank       <= 5'd1;
      st_q.upper_bank_bits    <= 2'd0;
      st_q.bank_mode          <= 1'b0;
      st_q.mbc3_rom_select    <= 7'd1;
      st_q.mbc3_ram_select    <= 2'd0;
      st_q.clock_reg_selected <= 1'b0;
    end else if (we_i && ok) begin
      st_q <= st_d;
    end
  end

  assign ctl_ok_o = ok;
  assign state_o  = st_q;

endmodule

[src/cartridge_bank_controller.sv]
// ----------------------------------------------------------------------------
// cartridge_bank_controller
// Game Boy style MBC1 / MBC3 bank controller for one CPU bus access at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one bus access: command,
//   bus address and write byte. Output channel (out_valid_o / out_ready_i)
//   returns exactly one result per access: target, physical ROM or RAM byte
//   offset and the byte to store.
//   A ROM read reduces its bank number modulo the ROM bank count in a
//   remainder unit that retires one bit per cycle over 7 bits; all other
//   commands skip it. The block takes one access at a time and takes no
//   new access until the last one has finished; the next access is taken
//   while the previous result waits in the output register.
//   Control writes update the bank registers when their result is loaded.
//   Configuration writes (cfg_we_i) take effect at once; the user is to
//   make them only while the block is idle (the block does not enforce it).
//   Reset: bank registers return to their power-up values, mapper mode plain,
//   two ROM banks, no RAM; no result is pending.
//   Receiver stall: the result holds in the output register; a finished
//   access waits in the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module cartridge_bank_controller import cbc_pkg::*; #(
  parameter int unsigned ROM_ADDR_BITS = 23
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic [15:0]         bus_address_i,
  input  logic [7:0]          write_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          target_o,
  output logic [MemAddrW-1:0] mem_address_o,
  output logic [7:0]          mem_data_o
);

  localparam int unsigned BankW = ROM_ADDR_BITS - RomOffW;
  localparam logic [BankCountW-1:0] MaxBanks = BankCountW'(1 << BankW);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} state_e;

  state_e                state_q;
  logic [1:0]            mapper_q;
  logic [BankCountW-1:0] bank_count_q;
  logic [RamBytesW-1:0]  ram_bytes_q;
  logic [1:0]            cmd_q;
  logic [15:0]           addr_q;
  logic [7:0]            data_q;
  logic                  out_valid_q;
  logic [2:0]            target_q, target_d;
  logic [MemAddrW-1:0]   maddr_q, maddr_d;
  logic [7:0]            mdata_q, mdata_d;

  bank_state_t           bank;
  logic                  ctl_ok;
  logic                  ctl_we;
  logic                  mbc1, mbc3;
  logic                  in_xfer, out_free, finish;
  logic                  rom_go;
  logic [RomBankW-1:0]   rom_bank;
  logic [BankCountW-1:0] divisor;
  logic                  div_done;
  logic [RomBankW-1:0]   rem;
  logic                  ram_ok;
  logic [1:0]            ram_bank;
  logic [RamOffW+1:0]    ram_off;

  assign mbc1     = (mapper_q == MODE_MBC1);
  assign mbc3     = (mapper_q == MODE_MBC3);
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign finish   = (state_q == S_DONE) && out_free;
  assign ctl_we   = finish && (cmd_q == CMD_CTL_WRITE);
  assign rom_go   = (command_i == CMD_ROM_READ) && !bus_address_i[15];

  // bank number seen by the ROM window, before wrap
  always_comb begin
    rom_bank = '0;
    if (!bus_address_i[14]) begin
      if (mbc1 && bank.bank_mode) begin
        rom_bank = {bank.upper_bank_bits, 5'd0};
      end
    end else if (mbc3) begin
      rom_bank = (bank.mbc3_rom_select == '0) ? 7'd1 : bank.mbc3_rom_select;
    end else begin
      rom_bank = {2'd0, (bank.low_rom_bank == '0) ? 5'd1 : bank.low_rom_bank};
      if (mbc1 && !bank.bank_mode) begin
        rom_bank[6:5] = bank.upper_bank_bits;
      end
    end
  end

  always_comb begin
    if (bank_count_q == '0) begin
      divisor = BankCountW'(1);
    end else if (bank_count_q > MaxBanks) begin
      divisor = MaxBanks;
    end else begin
      divisor = bank_count_q;
    end
  end

  cbc_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer && rom_go),
    .dividend_i (rom_bank),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  cbc_bank_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mapper_mode_i (mapper_q),
    .we_i          (ctl_we),
    .addr_i        (addr_q),
    .data_i        (data_q),
    .ctl_ok_o      (ctl_ok),
    .state_o       (bank)
  );

  // RAM window decode
  always_comb begin
    ram_bank = '0;
    if (mbc3) begin
      ram_bank = bank.mbc3_ram_select;
    end else if (mbc1 && bank.bank_mode) begin
      ram_bank = bank.upper_bank_bits;
    end
    ram_off = {ram_bank, addr_q[RamOffW-1:0]};
    ram_ok  = (addr_q[15:13] == 3'b101) && (ram_bytes_q != '0)
           && !((mbc1 || mbc3) && !bank.ram_enable)
           && !(mbc3 && bank.clock_reg_selected)
           && (RamBytesW'(ram_off) < ram_bytes_q);
  end

  always_comb begin
    target_d = TGT_OPEN_BUS;
    maddr_d  = '0;
    mdata_d  = '0;
    case (cmd_q)
      CMD_ROM_READ: begin
        if (!addr_q[15]) begin
          target_d = TGT_ROM_READ;
          maddr_d  = MemAddrW'({rem, addr_q[RomOffW-1:0]});
        end
      end
      CMD_CTL_WRITE: begin
        if (ctl_ok) begin
          target_d = TGT_CTL_ACK;
        end
      end
      default: begin
        if (ram_ok) begin
          maddr_d = MemAddrW'(ram_off);
          if (cmd_q == CMD_RAM_READ) begin
            target_d = TGT_RAM_READ;
          end else begin
            target_d = TGT_RAM_WRITE;
            mdata_d  = data_q;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      mapper_q     <= MODE_PLAIN;
      bank_count_q <= BankCountW'(2);
      ram_bytes_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAPPER_MODE:    mapper_q     <= cfg_data_i[1:0];
          CFG_ROM_BANK_COUNT: bank_count_q <= cfg_data_i[BankCountW-1:0];
          CFG_RAM_BYTES:      ram_bytes_q  <= cfg_data_i[RamBytesW-1:0];
          default: ;
        endcase
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= rom_go ? S_DIV : S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q  <= command_i;
      addr_q <= bus_address_i;
      data_q <= write_data_i;
    end
    if (finish) begin
      target_q <= target_d;
      maddr_q  <= maddr_d;
      mdata_q  <= mdata_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign target_o      = target_q;
  assign mem_address_o = maddr_q;
  assign mem_data_o    = mdata_q;

endmodule
